// ===== rtl/core/sws_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sws_pkg
// Types and constants shared by the stop-and-wait fragment sender.
// ----------------------------------------------------------------------------
package sws_pkg;

	// field widths
	localparam int MSG_W      = 20;
	localparam int ACK_ID_W   = 32;
	localparam int FRAG_W     = 16;
	localparam int PAY_W      = 11;
	localparam int SIZE_W     = 16;
	localparam int RT_W       = 32;
	localparam int SUM_W      = 48;
	localparam int TMO_W      = 32;
	localparam int OFF_W      = FRAG_W + PAY_W;
	localparam int CFG_DATA_W = 32;
	localparam int CFG_IDX_W  = 2;

	localparam logic [PAY_W-1:0] PAYLOAD_LIMIT = PAY_W'(1400);

	// register reset values
	localparam logic [MSG_W-1:0]  RST_MESSAGE_COUNT = MSG_W'(1000);
	localparam logic [TMO_W-1:0]  RST_TIMEOUT_TICKS = TMO_W'(1000000);
	localparam logic [SIZE_W-1:0] RST_TOTAL_SIZE    = SIZE_W'(10000);
	localparam logic [PAY_W-1:0]  RST_MAX_PAYLOAD   = PAYLOAD_LIMIT;

	localparam int QUEUE_DEPTH = 2;

	typedef enum logic [1:0] {
		CMD_START = 2'd0,
		CMD_TICK  = 2'd1,
		CMD_ACK   = 2'd2,
		CMD_LERR  = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		RK_SEND    = 2'd0,
		RK_DONE    = 2'd1,
		RK_FAIL    = 2'd2,
		RK_SUMMARY = 2'd3
	} kind_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_MESSAGE_COUNT = 2'd0,
		REG_TIMEOUT_TICKS = 2'd1,
		REG_TOTAL_SIZE    = 2'd2,
		REG_MAX_PAYLOAD   = 2'd3
	} reg_idx_t;

	typedef enum logic [1:0] {
		PH_IDLE,
		PH_RUN,
		PH_FINISHED
	} phase_t;

	typedef enum logic [3:0] {
		B_IDLE,
		B_DIV,
		B_MUL,
		B_FRAG,
		B_DONE,
		B_FAIL,
		B_NEXT,
		B_SUM
	} back_state_t;

	typedef struct packed {
		logic [MSG_W-1:0]  message_count;
		logic [TMO_W-1:0]  timeout_ticks;
		logic [SIZE_W-1:0] total_size;
		logic [PAY_W-1:0]  max_payload;
	} cfg_t;

	// classified event word as it sits in the queue
	typedef struct packed {
		cmd_t              op;
		logic [MSG_W-1:0]  ack_id;
		logic              ack_id_fits;
		logic [FRAG_W-1:0] ack_fragment;
		logic              ack_size_ok;
	} op_item_t;

	typedef struct packed {
		kind_t             result_kind;
		logic [MSG_W-1:0]  message_id;
		logic [FRAG_W-1:0] fragment_index;
		logic [FRAG_W-1:0] fragment_total;
		logic [PAY_W-1:0]  payload_bytes;
		logic [FRAG_W-1:0] payload_offset;
		logic [RT_W-1:0]   round_trip;
		logic [RT_W-1:0]   least_round_trip;
		logic [RT_W-1:0]   greatest_round_trip;
		logic [SUM_W-1:0]  round_trip_total;
		logic [MSG_W-1:0]  good_messages;
		logic [TMO_W-1:0]  timeout_total;
	} result_t;

	function automatic logic [PAY_W-1:0] eff_payload(input logic [PAY_W-1:0] p);
		logic [PAY_W-1:0] r;
		if (p == '0)
			r = PAY_W'(1);
		else if (p > PAYLOAD_LIMIT)
			r = PAYLOAD_LIMIT;
		else
			r = p;
		return r;
	endfunction

	function automatic logic [SIZE_W-1:0] eff_size(input logic [SIZE_W-1:0] s);
		return (s == '0) ? SIZE_W'(1) : s;
	endfunction

endpackage

// ===== rtl/core/sws_event_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sws_event_if
// Event channel into the sender: command and ack fields.
// ----------------------------------------------------------------------------
interface sws_event_if;
	logic                          valid;
	logic                          ready;
	logic [1:0]                    command;
	logic [sws_pkg::ACK_ID_W-1:0]  ack_message;
	logic [sws_pkg::FRAG_W-1:0]    ack_fragment;
	logic                          ack_size_ok;

	modport source (output valid, command, ack_message, ack_fragment, ack_size_ok,
		input ready);
	modport sink (input valid, command, ack_message, ack_fragment, ack_size_ok,
		output ready);
endinterface

// ===== rtl/core/sws_result_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sws_result_if
// Result channel out of the sender: fragment headers, message and run reports.
// ----------------------------------------------------------------------------
interface sws_result_if;
	logic                       valid;
	logic                       ready;
	logic [1:0]                 result_kind;
	logic [sws_pkg::MSG_W-1:0]  message_id;
	logic [sws_pkg::FRAG_W-1:0] fragment_index;
	logic [sws_pkg::FRAG_W-1:0] fragment_total;
	logic [sws_pkg::PAY_W-1:0]  payload_bytes;
	logic [sws_pkg::FRAG_W-1:0] payload_offset;
	logic [sws_pkg::RT_W-1:0]   round_trip;
	logic [sws_pkg::RT_W-1:0]   least_round_trip;
	logic [sws_pkg::RT_W-1:0]   greatest_round_trip;
	logic [sws_pkg::SUM_W-1:0]  round_trip_total;
	logic [sws_pkg::MSG_W-1:0]  good_messages;
	logic [sws_pkg::TMO_W-1:0]  timeout_total;

	modport source (output valid, result_kind, message_id, fragment_index, fragment_total,
		payload_bytes, payload_offset, round_trip, least_round_trip,
		greatest_round_trip, round_trip_total, good_messages, timeout_total,
		input ready);
	modport sink (input valid, result_kind, message_id, fragment_index, fragment_total,
		payload_bytes, payload_offset, round_trip, least_round_trip,
		greatest_round_trip, round_trip_total, good_messages, timeout_total,
		output ready);
endinterface

// ===== rtl/core/sws_cfg_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sws_cfg_if
// Register write channel: register index and write data.
// ----------------------------------------------------------------------------
interface sws_cfg_if;
	logic                             valid;
	logic                             ready;
	logic [sws_pkg::CFG_IDX_W-1:0]    index;
	logic [sws_pkg::CFG_DATA_W-1:0]   data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

// ===== rtl/core/sws_div.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sws_div
// Restoring divider, one quotient bit per cycle, giving the rounded-up
// quotient of message size by payload size.
// ----------------------------------------------------------------------------
module sws_div (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic [sws_pkg::SIZE_W-1:0] dividend,
	input  logic [sws_pkg::PAY_W-1:0]  divisor,
	output logic                       done,
	output logic [sws_pkg::FRAG_W-1:0] quotient_ceil
);
	localparam int CNT_W = $clog2(sws_pkg::SIZE_W);

	logic                       busy_q;
	logic                       done_q;
	logic [CNT_W-1:0]           cnt_q;
	logic [sws_pkg::SIZE_W-1:0] quo_q;
	logic [sws_pkg::PAY_W-1:0]  rem_q;
	logic [sws_pkg::PAY_W-1:0]  div_q;
	logic [sws_pkg::PAY_W:0]    rem_sh;
	logic                       q_bit;
	logic [sws_pkg::PAY_W:0]    rem_sub;

	// dividend bits shift out of the top of the quotient register
	assign rem_sh  = {rem_q, quo_q[sws_pkg::SIZE_W-1]};
	assign q_bit   = rem_sh >= {1'b0, div_q};
	assign rem_sub = q_bit ? rem_sh - {1'b0, div_q} : rem_sh;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + CNT_W'(1);
				if (cnt_q == CNT_W'(sws_pkg::SIZE_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			div_q <= divisor;
		end else if (busy_q) begin
			quo_q <= {quo_q[sws_pkg::SIZE_W-2:0], q_bit};
			rem_q <= rem_sub[sws_pkg::PAY_W-1:0];
		end
	end

	assign done          = done_q;
	assign quotient_ceil = quo_q + sws_pkg::FRAG_W'(rem_q != '0);
endmodule

// ===== rtl/core/sws_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sws_queue
// Short queue of classified event words between front and back.
// ----------------------------------------------------------------------------
module sws_queue (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  sws_pkg::op_item_t   push_item,
	output logic                full,
	input  logic                pop,
	output logic                not_empty,
	output sws_pkg::op_item_t   head
);
	localparam int DEPTH = sws_pkg::QUEUE_DEPTH;
	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	sws_pkg::op_item_t entries_q [DEPTH];
	logic [PTR_W-1:0]  wr_ptr_q;
	logic [PTR_W-1:0]  rd_ptr_q;
	logic [CNT_W-1:0]  count_q;

	assign full      = count_q == CNT_W'(DEPTH);
	assign not_empty = count_q != '0;
	assign head      = entries_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push)
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
			if (pop)
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
			if (push && !pop)
				count_q <= count_q + CNT_W'(1);
			else if (pop && !push)
				count_q <= count_q - CNT_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (push)
			entries_q[wr_ptr_q] <= push_item;
	end
endmodule

// ===== rtl/core/sws_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sws_front
// Event intake: takes words while the queue has room and classifies them.
// ----------------------------------------------------------------------------
module sws_front (
	sws_event_if.sink          events,
	input  logic               q_full,
	output logic               push,
	output sws_pkg::op_item_t  item
);
	assign events.ready = !q_full;
	assign push         = events.valid && !q_full;

	always_comb begin
		item.op           = sws_pkg::cmd_t'(events.command);
		item.ack_id       = events.ack_message[sws_pkg::MSG_W-1:0];
		// message ids are 20 bits, so any high bit set can never match
		item.ack_id_fits  = events.ack_message[sws_pkg::ACK_ID_W-1:sws_pkg::MSG_W] == '0;
		item.ack_fragment = events.ack_fragment;
		item.ack_size_ok  = events.ack_size_ok;
	end
endmodule

// ===== rtl/core/sws_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sws_back
// Protocol sequencer: keeps run state and statistics, carries out queued
// events and loads results into the output register.
// ----------------------------------------------------------------------------
module sws_back #(
	parameter int TIME_BITS = 32
) (
	input  logic               clk,
	input  logic               arst_n,
	input  sws_pkg::cfg_t      cfg,
	input  logic               q_valid,
	input  sws_pkg::op_item_t  q_item,
	output logic               q_pop,
	sws_result_if.source       results
);
	localparam int MW = sws_pkg::MSG_W;
	localparam int FW = sws_pkg::FRAG_W;
	localparam int PW = sws_pkg::PAY_W;

	sws_pkg::back_state_t state_q, state_d;
	sws_pkg::phase_t      phase_q;

	logic [MW-1:0]             cur_msg_q;
	logic [FW-1:0]             cur_frag_q;
	logic [FW-1:0]             fpm_q;
	logic [TIME_BITS-1:0]      wait_q;
	logic [TIME_BITS-1:0]      elapsed_q;
	logic [sws_pkg::RT_W-1:0]  min_q;
	logic [sws_pkg::RT_W-1:0]  max_q;
	logic [sws_pkg::SUM_W-1:0] sum_q;
	logic [MW-1:0]             succ_q;
	logic [sws_pkg::TMO_W-1:0] tmo_q;
	logic [sws_pkg::OFF_W-1:0] off_q;

	logic                out_valid_q;
	sws_pkg::result_t    out_q;
	sws_pkg::result_t    out_d;
	logic                out_free;
	logic                out_load;

	logic                running;
	logic [PW-1:0]       pay_eff;
	logic [sws_pkg::SIZE_W-1:0] size_eff;
	logic [TIME_BITS-1:0] wait_inc;
	logic [TIME_BITS-1:0] elapsed_inc;
	logic                timeout_hit;
	logic                ack_match;
	logic                more_frags;
	logic                has_next;
	logic [63:0]         elapsed_w;
	logic [sws_pkg::RT_W-1:0]  rt;
	logic [sws_pkg::SUM_W:0]   sum_add;
	logic                off_in_msg;
	logic [sws_pkg::SIZE_W-1:0] bytes_left;
	logic [PW-1:0]       chunk;
	logic                div_start;
	logic                div_done;
	logic [FW-1:0]       div_ceil;

	sws_div u_div (
		.clk           (clk),
		.arst_n        (arst_n),
		.start         (div_start),
		.dividend      (size_eff),
		.divisor       (pay_eff),
		.done          (div_done),
		.quotient_ceil (div_ceil)
	);

	assign running  = phase_q == sws_pkg::PH_RUN;
	assign pay_eff  = sws_pkg::eff_payload(cfg.max_payload);
	assign size_eff = sws_pkg::eff_size(cfg.total_size);
	assign out_free = !out_valid_q || results.ready;

	assign wait_inc    = (wait_q == '1) ? wait_q : wait_q + TIME_BITS'(1);
	assign elapsed_inc = (elapsed_q == '1) ? elapsed_q : elapsed_q + TIME_BITS'(1);
	assign timeout_hit = 64'(wait_inc) >= 64'(cfg.timeout_ticks);

	assign ack_match = q_item.ack_size_ok && q_item.ack_id_fits &&
		q_item.ack_id == cur_msg_q && q_item.ack_fragment == cur_frag_q;
	assign more_frags = (17'(cur_frag_q) + 17'd1) < 17'(fpm_q);
	assign has_next   = (21'(cur_msg_q) + 21'd1) < 21'(cfg.message_count);

	// round trip clamps to 32 bits when the tick counter is wider
	assign elapsed_w = 64'(elapsed_q);
	assign rt = (elapsed_w > 64'(32'hFFFF_FFFF)) ? '1 : elapsed_w[sws_pkg::RT_W-1:0];
	assign sum_add = (sws_pkg::SUM_W+1)'(sum_q) + (sws_pkg::SUM_W+1)'(rt);

	assign off_in_msg = off_q < sws_pkg::OFF_W'(size_eff);
	assign bytes_left = size_eff - off_q[sws_pkg::SIZE_W-1:0];
	assign chunk = !off_in_msg ? '0 :
		(bytes_left > sws_pkg::SIZE_W'(pay_eff)) ? pay_eff : bytes_left[PW-1:0];

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			sws_pkg::B_IDLE: begin
				if (q_valid) begin
					unique case (q_item.op)
						sws_pkg::CMD_START: state_d = sws_pkg::B_DIV;
						sws_pkg::CMD_TICK:
							state_d = (running && timeout_hit) ? sws_pkg::B_MUL : sws_pkg::B_IDLE;
						sws_pkg::CMD_ACK: begin
							if (!running)
								state_d = sws_pkg::B_IDLE;
							else if (!ack_match || more_frags)
								state_d = sws_pkg::B_MUL;
							else
								state_d = sws_pkg::B_DONE;
						end
						sws_pkg::CMD_LERR:
							state_d = running ? sws_pkg::B_FAIL : sws_pkg::B_IDLE;
						default: state_d = sws_pkg::B_IDLE;
					endcase
				end
			end
			sws_pkg::B_DIV: begin
				if (div_done)
					state_d = (cfg.message_count == '0) ? sws_pkg::B_SUM : sws_pkg::B_MUL;
			end
			sws_pkg::B_MUL:  state_d = sws_pkg::B_FRAG;
			sws_pkg::B_FRAG: if (out_free) state_d = sws_pkg::B_IDLE;
			sws_pkg::B_DONE: if (out_free) state_d = sws_pkg::B_NEXT;
			sws_pkg::B_FAIL: if (out_free) state_d = sws_pkg::B_NEXT;
			sws_pkg::B_NEXT: state_d = has_next ? sws_pkg::B_MUL : sws_pkg::B_SUM;
			sws_pkg::B_SUM:  if (out_free) state_d = sws_pkg::B_IDLE;
			default:         state_d = sws_pkg::B_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		q_pop     = 1'b0;
		div_start = 1'b0;
		out_load  = 1'b0;
		out_d     = '0;
		out_d.message_id     = cur_msg_q;
		out_d.fragment_total = fpm_q;
		unique case (state_q)
			sws_pkg::B_IDLE: begin
				q_pop     = q_valid;
				div_start = q_valid && q_item.op == sws_pkg::CMD_START;
			end
			sws_pkg::B_FRAG: begin
				out_load             = out_free;
				out_d.result_kind    = sws_pkg::RK_SEND;
				out_d.fragment_index = cur_frag_q;
				out_d.payload_bytes  = chunk;
				out_d.payload_offset = off_q[FW-1:0];
			end
			sws_pkg::B_DONE: begin
				out_load          = out_free;
				out_d.result_kind = sws_pkg::RK_DONE;
				out_d.round_trip  = rt;
			end
			sws_pkg::B_FAIL: begin
				out_load          = out_free;
				out_d.result_kind = sws_pkg::RK_FAIL;
			end
			sws_pkg::B_SUM: begin
				out_load                  = out_free;
				out_d.result_kind         = sws_pkg::RK_SUMMARY;
				out_d.message_id          = cur_msg_q + MW'(1);
				out_d.least_round_trip    = (succ_q == '0) ? '0 : min_q;
				out_d.greatest_round_trip = max_q;
				out_d.round_trip_total    = sum_q;
				out_d.good_messages       = succ_q;
				out_d.timeout_total       = tmo_q;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= sws_pkg::B_IDLE;
			phase_q     <= sws_pkg::PH_IDLE;
			out_valid_q <= 1'b0;
			cur_msg_q   <= '0;
			cur_frag_q  <= '0;
			fpm_q       <= '0;
			wait_q      <= '0;
			elapsed_q   <= '0;
			min_q       <= '1;
			max_q       <= '0;
			sum_q       <= '0;
			succ_q      <= '0;
			tmo_q       <= '0;
		end else begin
			state_q <= state_d;

			if (out_load)
				out_valid_q <= 1'b1;
			else if (results.ready)
				out_valid_q <= 1'b0;

			if (q_pop) begin
				unique case (q_item.op)
					sws_pkg::CMD_START: begin
						phase_q    <= sws_pkg::PH_RUN;
						cur_msg_q  <= '0;
						cur_frag_q <= '0;
						wait_q     <= '0;
						elapsed_q  <= '0;
						min_q      <= '1;
						max_q      <= '0;
						sum_q      <= '0;
						succ_q     <= '0;
						tmo_q      <= '0;
					end
					sws_pkg::CMD_TICK: begin
						if (running) begin
							elapsed_q <= elapsed_inc;
							if (timeout_hit) begin
								wait_q <= '0;
								if (tmo_q != '1)
									tmo_q <= tmo_q + sws_pkg::TMO_W'(1);
							end else begin
								wait_q <= wait_inc;
							end
						end
					end
					sws_pkg::CMD_ACK: begin
						if (running) begin
							wait_q <= '0;
							if (ack_match && more_frags)
								cur_frag_q <= cur_frag_q + FW'(1);
						end
					end
					default: ;
				endcase
			end

			if (state_q == sws_pkg::B_DIV && div_done)
				fpm_q <= div_ceil;

			if (state_q == sws_pkg::B_DONE && out_load) begin
				if (rt < min_q)
					min_q <= rt;
				if (rt > max_q)
					max_q <= rt;
				sum_q <= sum_add[sws_pkg::SUM_W] ? '1 : sum_add[sws_pkg::SUM_W-1:0];
				if (succ_q != '1)
					succ_q <= succ_q + MW'(1);
			end

			if (state_q == sws_pkg::B_NEXT && has_next) begin
				cur_msg_q  <= cur_msg_q + MW'(1);
				cur_frag_q <= '0;
				wait_q     <= '0;
				elapsed_q  <= '0;
			end

			if (state_q == sws_pkg::B_SUM && out_load)
				phase_q <= sws_pkg::PH_FINISHED;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == sws_pkg::B_MUL)
			off_q <= sws_pkg::OFF_W'(cur_frag_q) * sws_pkg::OFF_W'(pay_eff);
		if (out_load)
			out_q <= out_d;
	end

	assign results.valid               = out_valid_q;
	assign results.result_kind         = out_q.result_kind;
	assign results.message_id          = out_q.message_id;
	assign results.fragment_index      = out_q.fragment_index;
	assign results.fragment_total      = out_q.fragment_total;
	assign results.payload_bytes       = out_q.payload_bytes;
	assign results.payload_offset      = out_q.payload_offset;
	assign results.round_trip          = out_q.round_trip;
	assign results.least_round_trip    = out_q.least_round_trip;
	assign results.greatest_round_trip = out_q.greatest_round_trip;
	assign results.round_trip_total    = out_q.round_trip_total;
	assign results.good_messages       = out_q.good_messages;
	assign results.timeout_total       = out_q.timeout_total;
endmodule

// ===== rtl/core/stop_and_wait_fragment_sender.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stop_and_wait_fragment_sender
// Stop-and-wait sender that fragments messages and measures round trips.
// ----------------------------------------------------------------------------
// Events (start, tick, ack, link error) enter a two-word queue and are
// carried out by a sequencer that owns the run state. A tick or ack that
// causes no send is retired from the idle state, so such events run at
// one per cycle. An event that sends a fragment goes through retire, offset
// multiply and result load. A start runs a 16-step divider for the fragment
// count before its first result. An ack or link error that ends a message
// gives two results: its done or fail report, then a send or the summary.
// Results wait in an output register, so the queue keeps filling while the
// result side stalls. Round trips count ticks in TIME_BITS-bit counters.
module stop_and_wait_fragment_sender #(
	parameter int TIME_BITS = 32
) (
	input  logic          clk,
	input  logic          arst_n,
	sws_event_if.sink     events,
	sws_result_if.source  results,
	sws_cfg_if.sink       cfg
);
	sws_pkg::cfg_t     cfg_q;
	logic              q_full;
	logic              q_push;
	logic              q_pop;
	logic              q_valid;
	sws_pkg::op_item_t push_item;
	sws_pkg::op_item_t head_item;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.message_count <= sws_pkg::RST_MESSAGE_COUNT;
			cfg_q.timeout_ticks <= sws_pkg::RST_TIMEOUT_TICKS;
			cfg_q.total_size    <= sws_pkg::RST_TOTAL_SIZE;
			cfg_q.max_payload   <= sws_pkg::RST_MAX_PAYLOAD;
		end else if (cfg.valid) begin
			unique case (sws_pkg::reg_idx_t'(cfg.index))
				sws_pkg::REG_MESSAGE_COUNT:
					cfg_q.message_count <= cfg.data[sws_pkg::MSG_W-1:0];
				sws_pkg::REG_TIMEOUT_TICKS:
					cfg_q.timeout_ticks <= cfg.data[sws_pkg::TMO_W-1:0];
				sws_pkg::REG_TOTAL_SIZE:
					cfg_q.total_size <= cfg.data[sws_pkg::SIZE_W-1:0];
				sws_pkg::REG_MAX_PAYLOAD:
					cfg_q.max_payload <= cfg.data[sws_pkg::PAY_W-1:0];
				default: ;
			endcase
		end
	end

	sws_front u_front (
		.events (events),
		.q_full (q_full),
		.push   (q_push),
		.item   (push_item)
	);

	sws_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_item (push_item),
		.full      (q_full),
		.pop       (q_pop),
		.not_empty (q_valid),
		.head      (head_item)
	);

	sws_back #(
		.TIME_BITS (TIME_BITS)
	) u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg_q),
		.q_valid (q_valid),
		.q_item  (head_item),
		.q_pop   (q_pop),
		.results (results)
	);
endmodule
